// ----- design/hsd_pkg.sv -----
// ----------------------------------------------------------------------------
// hsd_pkg
// Shared types and constants for the five-point heat stencil step.
// ----------------------------------------------------------------------------
package hsd_pkg;

   localparam int TEMP_W       = 20;
   localparam int GRID_W       = 11;
   localparam int SRC_W        = 10;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 20;
   localparam int MAX_GRID_DEF = 1024;
   localparam int FIFO_DEPTH   = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_SIZE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_COL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_ROW  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_TEMP = 2'd3;

   // register reset values
   localparam int GRID_SIZE_RST = 1024;
   localparam logic [SRC_W-1:0]  SOURCE_COL_RST  = 10'd256;
   localparam logic [SRC_W-1:0]  SOURCE_ROW_RST  = 10'd256;
   localparam logic [TEMP_W-1:0] SOURCE_TEMP_RST = 20'd85248;

   // (6c + l + r + u + d + 5) / 10, divide done as multiply by reciprocal
   localparam int SUM_W     = TEMP_W + 4;
   localparam int DIV_SHIFT = 27;
   localparam logic [SUM_W-1:0] DIV_RECIP  = 24'd13421773;
   localparam logic [SUM_W-1:0] ROUND_BIAS = 24'd5;

   typedef struct packed {
      logic [TEMP_W-1:0] cell_temp;
      logic              flush;
   } req_payload_type;

   typedef struct packed {
      logic [TEMP_W-1:0] new_temp;
      logic              last_of_grid;
   } rsp_payload_type;

   // per-beat work handed from front to back (column travels alongside)
   typedef struct packed {
      logic [TEMP_W-1:0] temp;
      logic              emit;
      logic              top_edge;
      logic              bot_edge;
      logic              left_edge;
      logic              right_edge;
      logic              is_src;
      logic              last;
   } stage_info_type;

   typedef struct packed {
      logic is_src;
      logic last;
   } res_meta_type;

endpackage

// ----- design/hsd_fifo.sv -----
// ----------------------------------------------------------------------------
// hsd_fifo
// Small queue between the stencil front and back.
// ----------------------------------------------------------------------------
module hsd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = hsd_pkg::FIFO_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             full,
   output logic             empty
);
   import hsd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- design/hsd_front.sv -----
// ----------------------------------------------------------------------------
// hsd_front
// Accepts beats, tracks input and output raster positions, classifies each
// beat as cell, drain or drop, and queues the work for the back end.
// ----------------------------------------------------------------------------
module hsd_front #(
   parameter  int MAX_GRID = hsd_pkg::MAX_GRID_DEF,
   localparam int CW       = $clog2(MAX_GRID)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear,
   input  logic [CW-1:0]                 side_m1,
   input  logic [hsd_pkg::SRC_W-1:0]     src_row,
   input  logic [hsd_pkg::SRC_W-1:0]     src_col,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  hsd_pkg::req_payload_type      req_data,
   output logic                          push,
   output logic [CW-1:0]                 push_col,
   output hsd_pkg::stage_info_type       push_info
);
   import hsd_pkg::*;

   localparam int CMP_W = (CW > SRC_W) ? CW : SRC_W;

   logic [CW-1:0] in_row_ff, in_row_in;
   logic [CW-1:0] in_col_ff, in_col_in;
   logic [CW-1:0] out_row_ff, out_row_in;
   logic [CW-1:0] out_col_ff, out_col_in;
   logic          all_rcv_ff, all_rcv_in;

   logic accept, is_cell, emit, emit_cell;
   logic in_last, out_row_last, out_col_last, out_last;

   assign accept       = req_valid && !req_stall;
   assign is_cell      = !all_rcv_ff && !req_data.flush;
   assign in_last      = (in_row_ff == side_m1) && (in_col_ff == side_m1);
   assign out_row_last = (out_row_ff == side_m1);
   assign out_col_last = (out_col_ff == side_m1);
   assign out_last     = out_row_last && out_col_last;
   // a result is due once N+1 cells are in
   assign emit_cell    = (in_row_ff > CW'(1)) || ((in_row_ff == CW'(1)) && (in_col_ff != '0));
   assign emit         = is_cell ? emit_cell : 1'b1;

   // a cell beat or a drain beat; flushes before the last cell are dropped
   assign push = accept && (is_cell || all_rcv_ff);

   // drain beats walk the virtual column one ahead of the output column
   assign push_col = is_cell ? in_col_ff : (out_col_last ? '0 : out_col_ff + CW'(1));

   always_comb begin
      push_info            = '0;
      push_info.temp       = req_data.cell_temp;
      push_info.emit       = emit;
      push_info.top_edge   = (out_row_ff == '0);
      push_info.bot_edge   = out_row_last;
      push_info.left_edge  = (out_col_ff == '0);
      push_info.right_edge = out_col_last;
      push_info.is_src     = (CMP_W'(out_row_ff) == CMP_W'(src_row)) &&
                             (CMP_W'(out_col_ff) == CMP_W'(src_col));
      push_info.last       = out_last;
   end

   always_comb begin
      in_row_in  = in_row_ff;
      in_col_in  = in_col_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      all_rcv_in = all_rcv_ff;
      if (clear) begin
         in_row_in  = '0;
         in_col_in  = '0;
         out_row_in = '0;
         out_col_in = '0;
         all_rcv_in = 1'b0;
      end else if (accept) begin
         if (is_cell) begin
            if (in_last) begin
               all_rcv_in = 1'b1;
               in_row_in  = '0;
               in_col_in  = '0;
            end else if (in_col_ff == side_m1) begin
               in_col_in = '0;
               in_row_in = in_row_ff + CW'(1);
            end else begin
               in_col_in = in_col_ff + CW'(1);
            end
         end
         if (push && emit) begin
            if (out_last) begin
               out_row_in = '0;
               out_col_in = '0;
               all_rcv_in = 1'b0;
            end else if (out_col_last) begin
               out_col_in = '0;
               out_row_in = out_row_ff + CW'(1);
            end else begin
               out_col_in = out_col_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff  <= '0;
         in_col_ff  <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
         all_rcv_ff <= 1'b0;
      end else begin
         in_row_ff  <= in_row_in;
         in_col_ff  <= in_col_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
         all_rcv_ff <= all_rcv_in;
      end
   end

endmodule

// ----- design/hsd_back.sv -----
// ----------------------------------------------------------------------------
// hsd_back
// Line buffer, five-point window and arithmetic pipeline. One beat per cycle;
// the whole pipe holds while a finished result waits.
// ----------------------------------------------------------------------------
module hsd_back #(
   parameter  int MAX_GRID = hsd_pkg::MAX_GRID_DEF,
   localparam int CW       = $clog2(MAX_GRID)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [hsd_pkg::TEMP_W-1:0]     source_temp,
   input  logic                           q_empty,
   input  logic [CW-1:0]                  q_col,
   input  hsd_pkg::stage_info_type        q_info,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output hsd_pkg::rsp_payload_type       rsp_data
);
   import hsd_pkg::*;

   localparam int PROD_W = 2 * SUM_W;

   // each entry holds {two rows up, one row up} of a column
   logic [2*TEMP_W-1:0] line_buf_ff [MAX_GRID];
   logic [2*TEMP_W-1:0] rd_ff;

   logic            adv;
   logic            s1_v_ff;
   logic [CW-1:0]   s1_col_ff;
   stage_info_type  s1_info_ff;

   logic [TEMP_W-1:0] win_top_ff, win_mid_ff, win_bot_ff, win_left_ff;
   logic [TEMP_W-1:0] col_top, col_mid, col_bot;
   logic [TEMP_W-1:0] nb_left, nb_right, nb_up, nb_down;

   logic             s2_v_ff;
   logic [SUM_W-1:0] s2_sum_ff, sum_in;
   res_meta_type     s2_meta_ff;

   logic              s3_v_ff;
   logic [PROD_W-1:0] s3_prod_ff, prod_in;
   res_meta_type      s3_meta_ff;

   logic              rsp_valid_ff;
   rsp_payload_type   rsp_data_ff, rsp_data_in;

   assign adv   = !rsp_valid_ff || !rsp_stall;
   assign q_pop = adv && !q_empty;

   // stage 0: line buffer read
   always_ff @(posedge clock) begin
      if (q_pop) begin
         rd_ff <= line_buf_ff[q_col];
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s1_v_ff) begin
         line_buf_ff[s1_col_ff] <= {col_mid, col_bot};
      end
   end

   // stage 1: new column joins the window; centre is the previous column
   assign col_top = rd_ff[2*TEMP_W-1:TEMP_W];
   assign col_mid = rd_ff[TEMP_W-1:0];
   assign col_bot = s1_info_ff.temp;

   assign nb_left  = s1_info_ff.left_edge  ? win_mid_ff : win_left_ff;
   assign nb_right = s1_info_ff.right_edge ? win_mid_ff : col_mid;
   assign nb_up    = s1_info_ff.top_edge   ? win_mid_ff : win_top_ff;
   assign nb_down  = s1_info_ff.bot_edge   ? win_mid_ff : win_bot_ff;

   assign sum_in = (SUM_W'(win_mid_ff) << 2) + (SUM_W'(win_mid_ff) << 1)
                 + SUM_W'(nb_left) + SUM_W'(nb_right) + SUM_W'(nb_up) + SUM_W'(nb_down)
                 + ROUND_BIAS;

   // stage 2: divide by ten
   assign prod_in = PROD_W'(s2_sum_ff) * PROD_W'(DIV_RECIP);

   // stage 3: select and register the result
   always_comb begin
      rsp_data_in              = '0;
      rsp_data_in.new_temp     = s3_meta_ff.is_src ? source_temp
                                                   : s3_prod_ff[DIV_SHIFT +: TEMP_W];
      rsp_data_in.last_of_grid = s3_meta_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff      <= q_pop;
         s2_v_ff      <= s1_v_ff && s1_info_ff.emit;
         s3_v_ff      <= s2_v_ff;
         rsp_valid_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (q_pop) begin
            s1_col_ff  <= q_col;
            s1_info_ff <= q_info;
         end
         if (s1_v_ff) begin
            win_top_ff  <= col_top;
            win_mid_ff  <= col_mid;
            win_bot_ff  <= col_bot;
            win_left_ff <= win_mid_ff;
         end
         s2_sum_ff         <= sum_in;
         s2_meta_ff.is_src <= s1_info_ff.is_src;
         s2_meta_ff.last   <= s1_info_ff.last;
         s3_prod_ff        <= prod_in;
         s3_meta_ff        <= s2_meta_ff;
         rsp_data_ff       <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- design/heat_stencil_2d_step.sv -----
// Path: a result leaves after the beat that completes its window, through the
// queue, line buffer read, window and add, reciprocal multiply and output reg.
// The window trails the input stream by N+1 cells; flush beats drain the rest.
// Throughput: one beat per cycle without stalls, set by the single-port-pair buffer.
// Reset: synchronous; clears counters, queue and pipeline, restores register
// defaults. Line buffer contents are not cleared.
// ----------------------------------------------------------------------------
// heat_stencil_2d_step
// One Jacobi time step of a 2D five-point heat stencil on a raster stream.
// ----------------------------------------------------------------------------
module heat_stencil_2d_step #(
   parameter  int MAX_GRID = hsd_pkg::MAX_GRID_DEF,
   localparam int CW       = $clog2(MAX_GRID)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  hsd_pkg::req_payload_type          req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output hsd_pkg::rsp_payload_type          rsp_data,
   input  logic                              csr_we,
   input  logic [hsd_pkg::CSR_IDX_W-1:0]     csr_idx,
   input  logic [hsd_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import hsd_pkg::*;

   localparam int GW       = (GRID_W > CW + 1) ? GRID_W : CW + 1;
   localparam int RST_SIDE = (GRID_SIZE_RST > MAX_GRID) ? MAX_GRID : GRID_SIZE_RST;
   localparam int FW       = CW + $bits(stage_info_type);

   logic [CW-1:0]     side_m1_ff, side_m1_in;
   logic [SRC_W-1:0]  src_col_ff, src_col_in;
   logic [SRC_W-1:0]  src_row_ff, src_row_in;
   logic [TEMP_W-1:0] src_temp_ff, src_temp_in;
   logic [GW-1:0]     gs_ext, gs_clamped;
   logic              clear;

   logic           push, pop, q_full, q_empty;
   logic [CW-1:0]  push_col, head_col;
   stage_info_type push_info, head_info;
   logic [FW-1:0]  head_word;

   // side length clamped to [2, MAX_GRID], kept as N-1
   assign gs_ext     = GW'(csr_wdata[GRID_W-1:0]);
   assign gs_clamped = (gs_ext < GW'(2))        ? GW'(2) :
                       (gs_ext > GW'(MAX_GRID)) ? GW'(MAX_GRID) : gs_ext;
   assign clear      = csr_we && (csr_idx == CSR_GRID_SIZE);

   always_comb begin
      side_m1_in  = side_m1_ff;
      src_col_in  = src_col_ff;
      src_row_in  = src_row_ff;
      src_temp_in = src_temp_ff;
      if (csr_we) begin
         case (csr_idx)
            CSR_GRID_SIZE: begin
               side_m1_in = CW'(gs_clamped - GW'(1));
            end
            CSR_SOURCE_COL: begin
               src_col_in = csr_wdata[SRC_W-1:0];
            end
            CSR_SOURCE_ROW: begin
               src_row_in = csr_wdata[SRC_W-1:0];
            end
            CSR_SOURCE_TEMP: begin
               src_temp_in = csr_wdata[TEMP_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_m1_ff  <= CW'(RST_SIDE - 1);
         src_col_ff  <= SOURCE_COL_RST;
         src_row_ff  <= SOURCE_ROW_RST;
         src_temp_ff <= SOURCE_TEMP_RST;
      end else begin
         side_m1_ff  <= side_m1_in;
         src_col_ff  <= src_col_in;
         src_row_ff  <= src_row_in;
         src_temp_ff <= src_temp_in;
      end
   end

   assign req_stall = q_full || reset;

   hsd_front #(
      .MAX_GRID (MAX_GRID)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .clear     (clear),
      .side_m1   (side_m1_ff),
      .src_row   (src_row_ff),
      .src_col   (src_col_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .push      (push),
      .push_col  (push_col),
      .push_info (push_info)
   );

   hsd_fifo #(
      .WIDTH (FW),
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data ({push_col, push_info}),
      .rd_en   (pop),
      .rd_data (head_word),
      .full    (q_full),
      .empty   (q_empty)
   );

   assign head_col  = head_word[FW-1 -: CW];
   assign head_info = stage_info_type'(head_word[$bits(stage_info_type)-1:0]);

   hsd_back #(
      .MAX_GRID (MAX_GRID)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .source_temp (src_temp_ff),
      .q_empty     (q_empty),
      .q_col       (head_col),
      .q_info      (head_info),
      .q_pop       (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

// ----- design/hsd_check.sv -----
// ----------------------------------------------------------------------------
// hsd_check
// Port-level checks for the heat stencil step, bound to the top level.
// ----------------------------------------------------------------------------
module hsd_check (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input hsd_pkg::rsp_payload_type rsp_data
);
   import hsd_pkg::*;

   // a stalled result beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // and its payload does not move
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("stalled result payload changed");

   // the pipe is at least five stages deep and empty out of reset
   a_reset_drain: assert property (@(posedge clock)
      !reset && ($past(reset) || $past(reset, 2) || $past(reset, 3) || $past(reset, 4))
      |-> !rsp_valid)
      else $error("result beat too soon after reset");

   // queue is empty right after reset, so input is open
   a_open_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !req_stall)
      else $error("input stalled right after reset");

endmodule

bind heat_stencil_2d_step hsd_check u_hsd_check (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
